### rtl/core/bounded_list_insert_delete_assert.svh
// Assertion macros used by the bounded list engine.
`ifndef BOUNDED_LIST_INSERT_DELETE_ASSERT_SVH
`define BOUNDED_LIST_INSERT_DELETE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BLID_ASSERT_HOLD(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define BLID_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/blid_pkg.sv
// Types and constants of the bounded list block.
`timescale 1ns / 1ps
`default_nettype none

package blid_pkg;

  localparam int ValueWidth = 32;
  localparam int CountWidth = 5;
  localparam int QueueDepth = 2;

  // Command codes on the request channel.
  localparam logic [1:0] CmdRead    = 2'd0;
  localparam logic [1:0] CmdAppend  = 2'd1;
  localparam logic [1:0] CmdPrepend = 2'd2;
  localparam logic [1:0] CmdDelete  = 2'd3;

  // Status codes on the result channel.
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StEmpty    = 2'd3;

  typedef enum logic [1:0] {
    OpRead,
    OpAppend,
    OpPrepend,
    OpDelete
  } op_e;

  typedef struct packed {
    op_e                          op;
    logic signed [ValueWidth-1:0] value;
  } req_t;

endpackage

`default_nettype wire

### rtl/core/blid_if.sv
// Request and result channel interfaces of the bounded list block.
`timescale 1ns / 1ps
`default_nettype none

interface blid_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             command;
  logic signed [blid_pkg::ValueWidth-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface blid_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [blid_pkg::ValueWidth-1:0] entry_value;
  logic                                   has_value;
  logic [1:0]                             status;
  logic                                   last;
  logic [blid_pkg::CountWidth-1:0]        entry_count;

  modport source (output valid, output entry_value, output has_value, output status,
                  output last, output entry_count, input ready);
  modport sink (input valid, input entry_value, input has_value, input status,
                input last, input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/core/blid_front.sv
// Request front end: decodes commands and queues them for the list engine.
`timescale 1ns / 1ps
`default_nettype none

module blid_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  blid_in_if.sink         in_i,
  output logic            req_valid_o,
  output blid_pkg::req_t  req_o,
  input  wire             req_ready_i
);

  blid_pkg::req_t req_q [blid_pkg::QueueDepth];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;
  blid_pkg::req_t decoded;

  always_comb begin
    decoded.value = in_i.value;
    unique case (in_i.command)
      blid_pkg::CmdRead:    decoded.op = blid_pkg::OpRead;
      blid_pkg::CmdAppend:  decoded.op = blid_pkg::OpAppend;
      blid_pkg::CmdPrepend: decoded.op = blid_pkg::OpPrepend;
      blid_pkg::CmdDelete:  decoded.op = blid_pkg::OpDelete;
      default:              decoded.op = blid_pkg::OpRead;
    endcase
  end

  assign in_i.ready  = (cnt_q != 2'(blid_pkg::QueueDepth));
  assign push        = in_i.valid && in_i.ready;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = req_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      req_q[wr_ptr_q] <= decoded;
    end
  end

endmodule

`default_nettype wire

### rtl/core/blid_engine.sv
// List engine: circular entry store, command sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_list_insert_delete_assert.svh"

module blid_engine #(
  parameter int CAPACITY = 16
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             req_valid_i,
  input  blid_pkg::req_t  req_i,
  output logic            req_ready_o,
  blid_out_if.source      out_o
);

  localparam int PW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int VW = blid_pkg::ValueWidth;
  localparam int CW = blid_pkg::CountWidth;
  localparam logic [PW:0]   CapW  = (PW + 1)'(CAPACITY);
  localparam logic [LW-1:0] CapL  = LW'(CAPACITY);
  localparam logic [PW-1:0] LastP = PW'(CAPACITY - 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRd     = 3'd1;
  localparam logic [2:0] StRdEmit = 3'd2;
  localparam logic [2:0] StSrch   = 3'd3;
  localparam logic [2:0] StCmp    = 3'd4;
  localparam logic [2:0] StShift  = 3'd5;
  localparam logic [2:0] StMove   = 3'd6;

  // Physical slot of a list position, head at base.
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                         input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CapW) begin
      sum = sum - CapW;
    end
    return sum[PW-1:0];
  endfunction

  logic [VW-1:0]  mem_q [CAPACITY];
  logic [VW-1:0]  rd_data_q;
  logic           mem_we, mem_re;
  logic [PW-1:0]  mem_waddr, mem_raddr;
  logic [VW-1:0]  mem_wdata;

  logic [2:0]     state_q, state_d;
  logic [PW-1:0]  head_q, head_d;
  logic [LW-1:0]  len_q, len_d;
  logic [PW-1:0]  idx_q, idx_d;
  logic [VW-1:0]  key_q, key_d;

  logic           out_valid_q;
  logic [VW-1:0]  out_value_q;
  logic           out_has_q;
  logic [1:0]     out_status_q;
  logic           out_last_q;
  logic [CW-1:0]  out_count_q;

  logic           out_load;
  logic [VW-1:0]  ld_value;
  logic           ld_has;
  logic [1:0]     ld_status;
  logic           ld_last;
  logic [LW-1:0]  ld_len;

  logic           slot_free;
  logic           idx_last;
  logic           full, empty;
  logic [PW-1:0]  head_dec;

  assign slot_free = !out_valid_q || out_o.ready;
  assign idx_last  = ((LW'(idx_q) + LW'(1)) == len_q);
  assign full      = (len_q == CapL);
  assign empty     = (len_q == '0);
  assign head_dec  = (head_q == '0) ? LastP : head_q - PW'(1);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    len_d       = len_q;
    idx_d       = idx_q;
    key_d       = key_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = phys(head_q, idx_q);
    mem_raddr   = phys(head_q, idx_q);
    mem_wdata   = req_i.value;
    req_ready_o = 1'b0;
    out_load    = 1'b0;
    ld_value    = '0;
    ld_has      = 1'b0;
    ld_status   = blid_pkg::StOk;
    ld_last     = 1'b1;
    ld_len      = len_q;

    unique case (state_q)
      StIdle: begin
        // Take a request only when its first result has somewhere to go.
        if (req_valid_i && slot_free) begin
          req_ready_o = 1'b1;
          case (req_i.op)
            blid_pkg::OpRead: begin
              if (empty) begin
                out_load  = 1'b1;
                ld_status = blid_pkg::StEmpty;
              end else begin
                idx_d   = '0;
                state_d = StRd;
              end
            end
            blid_pkg::OpAppend: begin
              out_load = 1'b1;
              if (full) begin
                ld_status = blid_pkg::StFull;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_q, PW'(len_q));
                len_d     = len_q + LW'(1);
                ld_len    = len_q + LW'(1);
              end
            end
            blid_pkg::OpPrepend: begin
              out_load = 1'b1;
              if (full) begin
                ld_status = blid_pkg::StFull;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                head_d    = head_dec;
                len_d     = len_q + LW'(1);
                ld_len    = len_q + LW'(1);
              end
            end
            default: begin
              if (empty) begin
                out_load  = 1'b1;
                ld_status = blid_pkg::StEmpty;
              end else begin
                key_d   = req_i.value;
                idx_d   = '0;
                state_d = StSrch;
              end
            end
          endcase
        end
      end
      StRd: begin
        mem_re  = 1'b1;
        state_d = StRdEmit;
      end
      StRdEmit: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_value = rd_data_q;
          ld_has   = 1'b1;
          ld_last  = idx_last;
          if (idx_last) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + PW'(1);
            state_d = StRd;
          end
        end
      end
      StSrch: begin
        mem_re  = 1'b1;
        state_d = StCmp;
      end
      StCmp: begin
        if (rd_data_q == key_q) begin
          state_d = StShift;
        end else if (idx_last) begin
          if (slot_free) begin
            out_load  = 1'b1;
            ld_status = blid_pkg::StNotFound;
            state_d   = StIdle;
          end
        end else begin
          idx_d   = idx_q + PW'(1);
          state_d = StSrch;
        end
      end
      StShift: begin
        if (idx_last) begin
          if (slot_free) begin
            out_load = 1'b1;
            len_d    = len_q - LW'(1);
            ld_len   = len_q - LW'(1);
            state_d  = StIdle;
          end
        end else begin
          // Fetch the next entry to close the gap.
          mem_re    = 1'b1;
          mem_raddr = phys(head_q, idx_q + PW'(1));
          state_d   = StMove;
        end
      end
      StMove: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_q;
        idx_d     = idx_q + PW'(1);
        state_d   = StShift;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (out_load) begin
      out_value_q  <= ld_value;
      out_has_q    <= ld_has;
      out_status_q <= ld_status;
      out_last_q   <= ld_last;
      out_count_q  <= CW'(ld_len);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entry_value = out_value_q;
  assign out_o.has_value   = out_has_q;
  assign out_o.status      = out_status_q;
  assign out_o.last        = out_last_q;
  assign out_o.entry_count = out_count_q;

  `BLID_ASSERT_HOLD(a_len_bound, len_q <= CapL, "list length above capacity")
  `BLID_ASSERT_HOLD(a_head_bound, {1'b0, head_q} < CapW, "head pointer out of range")
  `BLID_ASSERT_IMPL(a_len_step, len_q != $past(len_q),
                    (len_q == $past(len_q) + LW'(1)) || (len_q + LW'(1) == $past(len_q)),
                    "list length moved by more than one")
  `BLID_ASSERT_IMPL(a_value_ok, out_load && ld_has, ld_status == blid_pkg::StOk,
                    "entry result without ok status")

endmodule

`default_nettype wire

### rtl/core/bounded_list_insert_delete.sv
// Bounded ordered list of signed 32-bit values: top level.
//
// Keeps up to CAPACITY entries, head to tail, in a circular single-port-read
// store. Requests: 0 read out (one result per entry, last marked; an empty
// list gives one result with status empty), 1 append at tail, 2 prepend at
// head, 3 delete first match. Inserts into a full list report status full,
// a delete that finds nothing reports not found; each of these commands gives
// one result. A two-deep request queue sits in front of the engine, and a
// result register decouples the output, so requests keep queueing while a
// result waits. The store's read port is registered. Inserts and the empty
// or full cases finish as the engine accepts them; readout reads and emits
// each entry in turn; a delete reads and compares each entry searched,
// fetches and writes each entry moved, then finishes. A result held on the
// output stalls the engine, where it has a new result to load, until it is
// taken. entry_count carries the length truncated to five bits.
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  blid_in_if.sink     in_i,
  blid_out_if.source  out_o
);

  logic           req_valid;
  logic           req_ready;
  blid_pkg::req_t req;

  blid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  blid_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
